>>> hdl/ipv4_flow_accounting_table_assert.svh
// assertion macros for the flow accounting table
`ifndef IPV4_FLOW_ACCOUNTING_TABLE_ASSERT_SVH
`define IPV4_FLOW_ACCOUNTING_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define FAT_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FAT_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FAT_ASSERT_IMP(label, clk, rst_n, a, c)
`define FAT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hdl/fat_pkg.sv
package fat_pkg;
  localparam int FLOW_ENTRIES = 64;
  localparam int IDX_W = $clog2(FLOW_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'h06;
  localparam logic [7:0] PROTO_UDP = 8'h11;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] ethertype;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] ip_total_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  flow_protocol;
    logic [31:0] flow_source;
    logic [31:0] flow_dest;
    logic [15:0] flow_source_port;
    logic [15:0] flow_dest_port;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
    logic [15:0] flows_lost;
    logic        last_record;
  } out_item_t;

  typedef struct packed {
    logic [63:0] addr_key;
    logic [39:0] pp_key;
    logic [15:0] tlen;
    logic        dump;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_CHECK, ST_UPDATE, ST_DUMP_RD, ST_DUMP_OUT
  } back_state_t;

  function automatic logic is_well_known(input logic [15:0] p);
    return p == 16'd20 || p == 16'd22 || p == 16'd23 || p == 16'd25 ||
           p == 16'd53 || p == 16'd80 || p == 16'd443;
  endfunction
endpackage

>>> hdl/ipv4_flow_accounting_table.sv
// channel | direction | handshake
// in_     | input     | start high and busy low
// out_    | output    | out_valid strobe, one cycle, no stall
// cfg_    | input     | cfg_valid and cfg_ready
// an ipv4 item is compared entry by entry (search, check) and then updated, other items are not queued
// a dump reads and outputs each stored entry in turn through the single table read port
// reset is synchronous, the table content is undefined until written
// busy is high while the two-entry queue is full
module ipv4_flow_accounting_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fat_pkg::in_item_t  in_item,
  output logic               out_valid,
  output fat_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [19:0]        cfg_data
);
  import fat_pkg::*;
  logic [19:0] threshold_r;
  job_t job_in, job_out;
  logic job_valid, pop, empty, full;

  assign cfg_ready = 1'b1;
  assign busy = full;

  always_ff @(posedge clk) begin
    if (!rst_n) threshold_r <= 20'd1000;
    else if (cfg_valid) threshold_r <= cfg_data;
  end

  fat_front u_front (.clk, .rst_n, .in_valid(start && !busy), .in_item,
    .threshold(threshold_r), .job(job_in), .job_valid);
  fat_queue u_queue (.clk, .rst_n, .push(job_valid), .push_data(job_in),
    .pop, .pop_data(job_out), .empty, .full);
  fat_back u_back (.clk, .rst_n, .job_present(!empty), .job(job_out),
    .job_pop(pop), .out_valid, .out_item);
endmodule

>>> hdl/fat_front.sv
module fat_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  fat_pkg::in_item_t in_item,
  input  logic [19:0]       threshold,
  output fat_pkg::job_t     job,
  output logic              job_valid
);
  import fat_pkg::*;
  logic [19:0] frame_count_r, frame_count_nxt;
  logic [15:0] sp, dp;
  logic ws, wd, tcpudp;

  always_comb begin
    frame_count_nxt = (frame_count_r != 20'hFFFFF) ? frame_count_r + 20'd1 : frame_count_r;
    tcpudp = in_item.ip_protocol == PROTO_TCP || in_item.ip_protocol == PROTO_UDP;
    ws = is_well_known(in_item.source_port);
    wd = is_well_known(in_item.dest_port);
    sp = in_item.source_port;
    dp = in_item.dest_port;
    if (!tcpudp) begin
      sp = '0;
      dp = '0;
    end else if (ws && !wd) begin
      dp = '0;
    end else if (wd && !ws) begin
      sp = '0;
    end
    job.addr_key = {in_item.source_address, in_item.dest_address};
    job.pp_key = {in_item.ip_protocol, sp, dp};
    job.tlen = in_item.ip_total_length;
    job.dump = frame_count_nxt >= threshold;
    job_valid = in_valid && in_item.ethertype == ETYPE_IPV4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
    end else if (job_valid && job.dump) begin
      frame_count_r <= '0;
    end else if (in_valid) begin
      frame_count_r <= frame_count_nxt;
    end
  end
endmodule

>>> hdl/fat_queue.sv
module fat_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fat_pkg::job_t push_data,
  input  logic          pop,
  output fat_pkg::job_t pop_data,
  output logic          empty,
  output logic          full
);
  import fat_pkg::*;
  job_t mem_r [QUEUE_DEPTH];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = cnt_r == 2'd0;
  assign full = cnt_r == 2'(QUEUE_DEPTH);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> hdl/fat_back.sv
`include "ipv4_flow_accounting_table_assert.svh"
module fat_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_present,
  input  fat_pkg::job_t      job,
  output logic               job_pop,
  output logic               out_valid,
  output fat_pkg::out_item_t out_item
);
  import fat_pkg::*;
  logic [63:0] addr_mem [FLOW_ENTRIES];
  logic [39:0] pp_mem [FLOW_ENTRIES];
  logic [31:0] pk_mem [FLOW_ENTRIES];
  logic [47:0] by_mem [FLOW_ENTRIES];
  logic [63:0] rd_addr_r;
  logic [39:0] rd_pp_r;
  logic [31:0] rd_pk_r;
  logic [47:0] rd_by_r;
  back_state_t st_r, st_nxt;
  logic [CNT_W-1:0] used_r, idx_r, idx_nxt;
  logic [15:0] lost_r;
  logic found_r;
  logic hit, at_end, wr_en, wr_new;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0] pk_new;
  logic [48:0] by_sum;
  logic [47:0] by_new;
  out_item_t out_r;
  logic out_valid_r;

  assign hit = rd_addr_r == job.addr_key && rd_pp_r == job.pp_key;
  assign at_end = idx_r + 1'b1 >= used_r;
  assign by_sum = {1'b0, rd_by_r} + 49'(job.tlen);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (job_present) st_nxt = (used_r == '0) ? ST_UPDATE : ST_SEARCH;
      ST_SEARCH: st_nxt = ST_CHECK;
      ST_CHECK: st_nxt = (hit || at_end) ? ST_UPDATE : ST_SEARCH;
      ST_UPDATE: st_nxt = job.dump ? ST_DUMP_RD : ST_IDLE;
      ST_DUMP_RD: st_nxt = (used_r == '0) ? ST_IDLE : ST_DUMP_OUT;
      ST_DUMP_OUT: st_nxt = at_end ? ST_IDLE : ST_DUMP_RD;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    wr_en = 1'b0;
    wr_new = 1'b0;
    job_pop = 1'b0;
    wr_idx = idx_r[IDX_W-1:0];
    pk_new = (rd_pk_r != 32'hFFFFFFFF) ? rd_pk_r + 32'd1 : rd_pk_r;
    by_new = by_sum[48] ? 48'hFFFFFFFFFFFF : by_sum[47:0];
    unique case (st_r)
      ST_IDLE: idx_nxt = '0;
      ST_CHECK: if (!hit && !at_end) idx_nxt = idx_r + 1'b1;
      ST_UPDATE: begin
        if (found_r) begin
          wr_en = 1'b1;
        end else if (used_r < CNT_W'(FLOW_ENTRIES)) begin
          wr_en = 1'b1;
          wr_new = 1'b1;
          wr_idx = used_r[IDX_W-1:0];
        end
        idx_nxt = '0;
        job_pop = !job.dump;
      end
      ST_DUMP_RD: job_pop = used_r == '0;
      ST_DUMP_OUT: begin
        idx_nxt = idx_r + 1'b1;
        job_pop = at_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= job.addr_key;
      pp_mem[wr_idx] <= job.pp_key;
      pk_mem[wr_idx] <= wr_new ? 32'd1 : pk_new;
      by_mem[wr_idx] <= wr_new ? 48'(job.tlen) : by_new;
    end
    rd_addr_r <= addr_mem[idx_nxt[IDX_W-1:0]];
    rd_pp_r <= pp_mem[idx_nxt[IDX_W-1:0]];
    rd_pk_r <= pk_mem[idx_nxt[IDX_W-1:0]];
    rd_by_r <= by_mem[idx_nxt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    out_r <= {rd_pp_r[39:32], rd_addr_r, rd_pp_r[31:0], rd_pk_r, rd_by_r, lost_r, at_end};
    if (!rst_n) begin
      st_r <= ST_IDLE;
      idx_r <= '0;
      used_r <= '0;
      lost_r <= '0;
      found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= st_r == ST_DUMP_OUT;
      if (st_r == ST_IDLE) found_r <= 1'b0;
      if (st_r == ST_CHECK && hit) found_r <= 1'b1;
      if (st_r == ST_UPDATE && !found_r) begin
        if (used_r < CNT_W'(FLOW_ENTRIES)) used_r <= used_r + 1'b1;
        else if (lost_r != 16'hFFFF) lost_r <= lost_r + 16'd1;
      end
      if (job_pop && job.dump) begin
        used_r <= '0;
        lost_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

  `FAT_ASSERT_IMP(a_used_max, clk, rst_n, 1'b1, used_r <= CNT_W'(FLOW_ENTRIES))
  `FAT_ASSERT_IMP(a_dump_idx, clk, rst_n, st_r == ST_DUMP_OUT, idx_r < used_r)
  `FAT_ASSERT_NXT(a_out_follows, clk, rst_n, st_r == ST_DUMP_OUT, out_valid_r)
endmodule
